// File: rtl/oiq_pkg.sv
// Shared constants, command and status codes, and sequencer states of the ordered insert queue.
package oiq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int ENT_W = 31;
    localparam int POS_W = 4;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    localparam logic [VAL_W-1:0] NONE_VALUE = '1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WRAP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage

// File: rtl/ordered_insert_queue_core.sv
// Top level of the ordered insert queue: command sequencer, entry store and result register.
//
//  Channel   Handshake             Payload
//  request   in_valid / in_ready   command, value, position
//  result    out_valid / out_ready status, result_value, count
//
// Push, clear, unused codes and rejected commands go straight to the result register; get reads one entry.
// Pop, insert and erase walk all stored entries through the one RAM port pair.
// Reset empties the queue at once; entries are not cleared.
// A new request is taken while the previous result still waits in the output register.
module ordered_insert_queue_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [oiq_pkg::CMD_W-1:0]           command,
    input  logic signed [oiq_pkg::VAL_W-1:0]    value,
    input  logic [oiq_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [oiq_pkg::ST_W-1:0]            status,
    output logic signed [oiq_pkg::VAL_W-1:0]    result_value,
    output logic [oiq_pkg::CNT_W-1:0]           count
);

    localparam int CMP_W = oiq_pkg::CNT_W + oiq_pkg::POS_W;

    oiq_pkg::state_t                state_reg, state_next;
    logic [oiq_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic                           out_valid_reg, out_valid_next;
    logic [oiq_pkg::ST_W-1:0]       status_reg, status_next;
    logic [oiq_pkg::VAL_W-1:0]      result_value_reg, result_value_next;
    logic [oiq_pkg::CNT_W-1:0]      count_reg, count_next;

    logic [oiq_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [oiq_pkg::ENT_W-1:0]      key_reg, key_next;
    logic                           neg_reg, neg_next;
    logic [oiq_pkg::CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [oiq_pkg::CNT_W-1:0]      rd_end_reg, rd_end_next;
    logic                           pend_reg, pend_next;
    logic [oiq_pkg::IDX_W-1:0]      pidx_reg, pidx_next;
    logic [oiq_pkg::CNT_W-1:0]      kept_reg, kept_next;
    logic                           found_reg, found_next;
    logic                           removed_reg, removed_next;
    logic [oiq_pkg::ENT_W-1:0]      carry_reg, carry_next;
    logic [oiq_pkg::ST_W-1:0]       res_st_reg, res_st_next;
    logic [oiq_pkg::VAL_W-1:0]      res_val_reg, res_val_next;

    logic                           ram_we;
    logic [oiq_pkg::IDX_W-1:0]      ram_waddr;
    logic [oiq_pkg::ENT_W-1:0]      ram_wdata;
    logic [oiq_pkg::ENT_W-1:0]      ram_rdata;

    logic                           accept;
    logic                           in_neg;
    logic                           full;
    logic                           issue;
    logic                           skip;

    oiq_ram #(
        .WIDTH (oiq_pkg::ENT_W),
        .DEPTH (oiq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[oiq_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ready     = (state_reg == oiq_pkg::S_IDLE);
    assign accept       = in_valid && in_ready;
    assign in_neg       = value[oiq_pkg::VAL_W-1];
    assign full         = (fill_reg >= oiq_pkg::CNT_W'(oiq_pkg::DEPTH));
    assign issue        = (rd_idx_reg < rd_end_reg);
    assign skip         = ((cmd_reg == oiq_pkg::CMD_POP) && (pidx_reg == '0))
                       || ((cmd_reg == oiq_pkg::CMD_ERASE) && !neg_reg && (ram_rdata == key_reg));
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = result_value_reg;
    assign count        = count_reg;

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        result_value_next = result_value_reg;
        count_next        = count_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        neg_next          = neg_reg;
        rd_idx_next       = rd_idx_reg;
        rd_end_next       = rd_end_reg;
        pend_next         = 1'b0;
        pidx_next         = pidx_reg;
        kept_next         = kept_reg;
        found_next        = found_reg;
        removed_next      = removed_reg;
        carry_next        = carry_reg;
        res_st_next       = res_st_reg;
        res_val_next      = res_val_reg;
        ram_we            = 1'b0;
        ram_waddr         = fill_reg[oiq_pkg::IDX_W-1:0];
        ram_wdata         = value[oiq_pkg::ENT_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            oiq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = command;
                    key_next     = value[oiq_pkg::ENT_W-1:0];
                    neg_next     = in_neg;
                    carry_next   = value[oiq_pkg::ENT_W-1:0];
                    rd_idx_next  = '0;
                    rd_end_next  = fill_reg;
                    kept_next    = '0;
                    found_next   = 1'b0;
                    removed_next = 1'b0;
                    res_st_next  = oiq_pkg::ST_OK;
                    res_val_next = '0;
                    state_next   = oiq_pkg::S_EMIT;
                    unique case (command)
                        oiq_pkg::CMD_PUSH:
                        begin
                            if (in_neg)
                            begin
                                res_st_next = oiq_pkg::ST_REJECT;
                            end
                            else if (full)
                            begin
                                res_st_next = oiq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        oiq_pkg::CMD_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_st_next  = oiq_pkg::ST_EMPTY;
                                res_val_next = oiq_pkg::NONE_VALUE;
                            end
                            else
                            begin
                                state_next = oiq_pkg::S_SCAN;
                            end
                        end
                        oiq_pkg::CMD_INSERT:
                        begin
                            if (in_neg)
                            begin
                                res_st_next = oiq_pkg::ST_REJECT;
                            end
                            else if (full)
                            begin
                                res_st_next = oiq_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = oiq_pkg::S_SCAN;
                            end
                        end
                        oiq_pkg::CMD_ERASE:
                        begin
                            state_next = oiq_pkg::S_SCAN;
                        end
                        oiq_pkg::CMD_GET:
                        begin
                            if (CMP_W'(position) < CMP_W'(fill_reg))
                            begin
                                rd_idx_next = oiq_pkg::CNT_W'(position);
                                rd_end_next = oiq_pkg::CNT_W'(position) + 1'b1;
                                state_next  = oiq_pkg::S_SCAN;
                            end
                            else
                            begin
                                res_st_next  = oiq_pkg::ST_EMPTY;
                                res_val_next = oiq_pkg::NONE_VALUE;
                            end
                        end
                        oiq_pkg::CMD_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            res_st_next = oiq_pkg::ST_OK;
                        end
                    endcase
                end
            end

            oiq_pkg::S_SCAN:
            begin
                if (issue)
                begin
                    pend_next   = 1'b1;
                    pidx_next   = rd_idx_reg[oiq_pkg::IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = oiq_pkg::S_WRAP;
                end

                if (pend_reg)
                begin
                    unique case (cmd_reg)
                        oiq_pkg::CMD_GET:
                        begin
                            res_val_next = {1'b0, ram_rdata};
                        end
                        oiq_pkg::CMD_INSERT:
                        begin
                            if (found_reg || (ram_rdata <= key_reg))
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = pidx_reg;
                                ram_wdata  = carry_reg;
                                carry_next = ram_rdata;
                                found_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (skip)
                            begin
                                removed_next = 1'b1;
                                if (cmd_reg == oiq_pkg::CMD_POP)
                                begin
                                    res_val_next = {1'b0, ram_rdata};
                                end
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = kept_reg[oiq_pkg::IDX_W-1:0];
                                ram_wdata = ram_rdata;
                                kept_next = kept_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end

            oiq_pkg::S_WRAP:
            begin
                state_next = oiq_pkg::S_EMIT;
                unique case (cmd_reg)
                    oiq_pkg::CMD_GET:
                    begin
                        res_st_next = oiq_pkg::ST_OK;
                    end
                    oiq_pkg::CMD_INSERT:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[oiq_pkg::IDX_W-1:0];
                        ram_wdata = carry_reg;
                        fill_next = fill_reg + 1'b1;
                    end
                    oiq_pkg::CMD_ERASE:
                    begin
                        fill_next   = kept_reg;
                        res_st_next = removed_reg ? oiq_pkg::ST_OK : oiq_pkg::ST_REJECT;
                    end
                    default:
                    begin
                        fill_next = kept_reg;
                    end
                endcase
            end

            oiq_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_st_reg;
                    result_value_next = res_val_reg;
                    count_next        = fill_reg;
                    state_next        = oiq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = oiq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oiq_pkg::S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        result_value_reg <= result_value_next;
        count_reg        <= count_next;
        cmd_reg          <= cmd_next;
        key_reg          <= key_next;
        neg_reg          <= neg_next;
        rd_idx_reg       <= rd_idx_next;
        rd_end_reg       <= rd_end_next;
        pidx_reg         <= pidx_next;
        kept_reg         <= kept_next;
        found_reg        <= found_next;
        removed_reg      <= removed_next;
        carry_reg        <= carry_next;
        res_st_reg       <= res_st_next;
        res_val_reg      <= res_val_next;
    end

endmodule

// File: rtl/oiq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module oiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/oiq_checker.sv
// Port-level assertions for the ordered insert queue and the bind that attaches them.
module oiq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [oiq_pkg::ST_W-1:0]            status,
    input logic signed [oiq_pkg::VAL_W-1:0]    result_value,
    input logic [oiq_pkg::CNT_W-1:0]           count
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(result_value) && $stable(count))
        else $error("result changed while stalled");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a command is in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= oiq_pkg::CNT_W'(oiq_pkg::DEPTH))
        else $error("count beyond queue depth");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == oiq_pkg::ST_EMPTY) |-> result_value == oiq_pkg::NONE_VALUE)
        else $error("empty status without the absent value");

    a_value_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != oiq_pkg::ST_EMPTY) |-> !result_value[oiq_pkg::VAL_W-1])
        else $error("negative value on a successful result");

endmodule

bind ordered_insert_queue_core oiq_checker u_oiq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_value (result_value),
    .count        (count)
);
